/* hdl/sgpf_pkg.sv */
// package for the softened gravity pair force unit
// holds widths, reset values, register codes and the item types used across the modules
// no dependencies
`default_nettype none

package sgpf_pkg;

    // queue between front and back
    localparam int SGPF_QUEUE_DEPTH = 4;

    // arithmetic widths
    localparam int POS_W   = 32;
    localparam int R2_W    = 64;
    localparam int RAD_W   = 96;
    localparam int ROOT_W  = 48;
    localparam int SQREM_W = 50;
    localparam int PROD_W  = 64;
    localparam int WIDE_W  = 112;
    localparam int CMP_W   = 144;

    // pipeline step counts
    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = 32;

    // configuration reset values
    localparam logic [31:0] GAIN_RESET   = 32'h0001_0000;
    localparam logic [62:0] RADIUS_RESET = 63'h0000_0001_0000_0000;

    // register codes, taken from paddr[3]
    localparam logic REG_GAIN           = 1'b0;
    localparam logic REG_SOFT_RADIUS_SQ = 1'b1;

    // item leaving the front part
    typedef struct packed {
        logic [2:0]            neg_d;
        logic [2:0][POS_W-1:0] mag_d;
        logic [R2_W-1:0]       r2;
        logic                  in_soft;
        logic                  sat;
    } t_front_item;

    // item travelling through the square root pipeline
    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][PROD_W-1:0] prod;
        logic [R2_W-1:0]        r2;
        logic                   in_soft;
        logic                   sat;
    } t_mid;

    // flags travelling through the divider pipeline
    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] ovf;
        logic       in_soft;
        logic       sat;
        logic       zero;
    } t_tail;

endpackage

`default_nettype wire

/* hdl/softened_gravity_pair_force_unit.sv */
// top level of the softened gravity pair force unit
// holds the configuration registers and joins front, queue and back; uses sgpf_pkg
//
// Use: a pair of positions (first x,y,z then second x,y,z, signed Q16.16) goes in
// on the slave stream; the acceleration increment for the first particle comes out
// on the master stream with the softening and clamp flags in tuser. The host adds
// it to the first particle and subtracts it from the second.
// Throughput: one pair per cycle, with no gaps between results, while tready stays high.
// Path: the front part, the queue, then the back part with its 48-stage square
// root and the 32-stage dividers, ending in the output register.
// Config: APB, 64-bit data, gain at address 0, soft_radius_sq at address 8;
// write only while the unit is empty. Reads return the stored values.
// Reset: synchronous, active low; clears all valid flags and the queue, gain
// returns to 1.0 and soft_radius_sq to 1.0.
// Stall: when the receiver holds tready low the back pipeline freezes, the
// front keeps accepting until the queue between them is full, then drops tready.
`default_nettype none

module softened_gravity_pair_force_unit
    import sgpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = SGPF_QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, 32 bits each
    input  wire logic [191:0] i_s_axis_tdata,
    // result stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // accel_x, accel_y, accel_z, 32 bits each
    output logic [95:0]       o_m_axis_tdata,
    // inside_soft, saturated
    output logic [1:0]        o_m_axis_tuser,
    // configuration
    input  wire logic         i_psel,
    input  wire logic         i_penable,
    input  wire logic         i_pwrite,
    input  wire logic [3:0]   i_paddr,
    input  wire logic [63:0]  i_pwdata,
    output logic [63:0]       o_prdata,
    output logic              o_pready
);

    logic [31:0] r_gain;
    logic [62:0] r_soft_radius_sq;
    logic        cfg_wr;

    // register writes on the access cycle
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain           <= GAIN_RESET;
            r_soft_radius_sq <= RADIUS_RESET;
        end else if (cfg_wr) begin
            unique case (i_paddr[3])
                REG_GAIN:           r_gain           <= i_pwdata[31:0];
                REG_SOFT_RADIUS_SQ: r_soft_radius_sq <= i_pwdata[62:0];
                default:            ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (i_paddr[3])
            REG_GAIN:           o_prdata = {32'd0, r_gain};
            REG_SOFT_RADIUS_SQ: o_prdata = {1'b0, r_soft_radius_sq};
            default:            o_prdata = '0;
        endcase
    end

    // front part
    logic        q_full, f_push, q_valid, b_pop;
    t_front_item f_item, q_item;

    sgpf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_data           (i_s_axis_tdata),
        .i_soft_radius_sq (r_soft_radius_sq),
        .i_full           (q_full),
        .o_push           (f_push),
        .o_item           (f_item)
    );

    // queue between the parts
    sgpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_item),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    // back part
    sgpf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (q_valid),
        .i_item           (q_item),
        .o_pop            (b_pop),
        .i_gain           (r_gain),
        .i_soft_radius_sq (r_soft_radius_sq),
        .o_valid          (o_m_axis_tvalid),
        .i_ready          (i_m_axis_tready),
        .o_data           (o_m_axis_tdata),
        .o_user           (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

/* hdl/sgpf_front.sv */
// front part: difference vector, saturation, squares and softening compare
// three register stages, stalls only when the queue is full; uses sgpf_pkg
`default_nettype none

module sgpf_front
    import sgpf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [6*POS_W-1:0] i_data,
    input  wire logic [62:0]       i_soft_radius_sq,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_front_item            o_item
);

    logic en;
    logic r_v1, r_v2, r_v3;

    logic [2:0]            n_neg;
    logic [2:0][POS_W-1:0] n_mag;
    logic                  n_sat;

    logic [2:0]            r_f1_neg;
    logic [2:0][POS_W-1:0] r_f1_mag;
    logic                  r_f1_sat;

    logic [2:0]            r_f2_neg;
    logic [2:0][POS_W-1:0] r_f2_mag;
    logic [2:0][R2_W-1:0]  r_f2_sq;
    logic                  r_f2_sat;

    logic [R2_W+1:0]       r2_sum;
    t_front_item           r_item;

    // stall only when the last stage cannot hand its item over
    assign en      = !(r_v3 && i_full);
    assign o_ready = en;
    assign o_push  = r_v3 && !i_full;
    assign o_item  = r_item;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // clamped differences and their magnitudes
    always_comb begin
        logic [POS_W:0]   diff;
        logic [POS_W-1:0] d;
        n_sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            diff = {i_data[(c+3)*POS_W+POS_W-1], i_data[(c+3)*POS_W +: POS_W]}
                 - {i_data[c*POS_W+POS_W-1], i_data[c*POS_W +: POS_W]};
            d = diff[POS_W-1:0];
            if (!diff[POS_W] && diff[POS_W-1]) begin
                d = 32'h7FFF_FFFF;
                n_sat = 1'b1;
            end else if (diff[POS_W] && !diff[POS_W-1]) begin
                d = 32'h8000_0000;
                n_sat = 1'b1;
            end
            n_neg[c] = d[POS_W-1];
            n_mag[c] = d[POS_W-1] ? (~d + 32'd1) : d;
        end
    end

    // squared length, sum and softening compare
    assign r2_sum = {2'b00, r_f2_sq[0]} + {2'b00, r_f2_sq[1]} + {2'b00, r_f2_sq[2]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_neg <= n_neg;
            r_f1_mag <= n_mag;
            r_f1_sat <= n_sat;
            r_f2_neg <= r_f1_neg;
            r_f2_mag <= r_f1_mag;
            r_f2_sat <= r_f1_sat;
            for (int c = 0; c < 3; c++) begin
                r_f2_sq[c] <= r_f1_mag[c] * r_f1_mag[c];
            end
            r_item.neg_d   <= r_f2_neg;
            r_item.mag_d   <= r_f2_mag;
            r_item.sat     <= r_f2_sat;
            r_item.r2      <= r2_sum[R2_W-1:0];
            r_item.in_soft <= ({1'b0, r2_sum[R2_W-1:0]} < {2'b00, i_soft_radius_sq});
        end
    end

endmodule

`default_nettype wire

/* hdl/sgpf_queue.sv */
// short queue between front and back parts
// register storage with one read address; uses sgpf_pkg
`default_nettype none

module sgpf_queue
    import sgpf_pkg::*;
#(
    parameter int DEPTH = SGPF_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_front_item i_data,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_valid,
    output t_front_item      o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_front_item      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/sgpf_sqrt.sv */
// pipelined integer square root, one result bit per stage
// carries the item alongside the root; uses sgpf_pkg
`default_nettype none

module sgpf_sqrt
    import sgpf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [RAD_W-1:0] i_rad,
    input  wire t_mid             i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output t_mid                  o_side
);

    logic               r_v    [SQ_STEPS];
    logic [SQREM_W-1:0] r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0]  r_root [SQ_STEPS];
    logic [RAD_W-1:0]   r_rad  [SQ_STEPS];
    t_mid               r_side [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic               v_in;
        logic [SQREM_W-1:0] rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [RAD_W-1:0]   rad_in;
        t_mid               side_in;
        logic [SQREM_W+1:0] acc, trial, diff;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down two bits and try the next root bit
        assign acc   = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = acc - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (acc >= trial) begin
                    r_rem[k]  <= diff[SQREM_W-1:0];
                    r_root[k] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= acc[SQREM_W-1:0];
                    r_root[k] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                r_rad[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];
    assign o_side  = r_side[SQ_STEPS-1];

endmodule

`default_nettype wire

/* hdl/sgpf_back.sv */
// back part: numerators, root, denominator, three pipelined dividers and clamp
// ends in the output register; uses sgpf_pkg and sgpf_sqrt
`default_nettype none

module sgpf_back
    import sgpf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_item_valid,
    input  wire t_front_item i_item,
    output logic             o_pop,
    input  wire logic [31:0] i_gain,
    input  wire logic [62:0] i_soft_radius_sq,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [95:0]      o_data,
    output logic [1:0]       o_user
);

    logic        en;
    logic [31:0] gain_mag;

    // whole back pipeline advances while the output register can move
    assign en    = !o_valid || i_ready;
    assign o_pop = en && i_item_valid;
    assign gain_mag = i_gain[31] ? (~i_gain + 32'd1) : i_gain;

    // numerators d * gain and signs
    logic r_b0_v;
    t_mid r_b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
        end else if (en) begin
            r_b0_v <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_b0.neg[c]  <= i_item.neg_d[c] ^ i_gain[31];
                r_b0.prod[c] <= i_item.mag_d[c] * gain_mag;
            end
            r_b0.r2      <= i_item.r2;
            r_b0.in_soft <= i_item.in_soft;
            r_b0.sat     <= i_item.sat;
        end
    end

    // root of r2 in Q16.32
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    t_mid              sq_side;

    sgpf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b0_v),
        .i_rad   ({r_b0.r2, 32'd0}),
        .i_side  (r_b0),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // partial products of r2 * root
    logic        r_m1_v;
    t_mid        r_m1;
    logic [63:0] r_pp_ll, r_pp_hl;
    logic [47:0] r_pp_lh, r_pp_hh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1    <= sq_side;
            r_pp_ll <= sq_side.r2[31:0] * sq_root[31:0];
            r_pp_lh <= sq_side.r2[31:0] * sq_root[47:32];
            r_pp_hl <= sq_side.r2[63:32] * sq_root[31:0];
            r_pp_hh <= sq_side.r2[63:32] * sq_root[47:32];
        end
    end

    // denominator sum and choice of path
    logic [WIDE_W-1:0]      den_far;
    logic                   r_m2_v;
    t_tail                  r_m2_tail;
    logic [WIDE_W-1:0]      r_m2_den;
    logic [2:0][WIDE_W-1:0] r_m2_num;

    assign den_far = {48'd0, r_pp_ll} + {32'd0, r_pp_lh, 32'd0}
                   + {16'd0, r_pp_hl, 32'd0} + {r_pp_hh, 64'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (en) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_tail.neg     <= r_m1.neg;
            r_m2_tail.ovf     <= '0;
            r_m2_tail.in_soft <= r_m1.in_soft;
            r_m2_tail.sat     <= r_m1.sat;
            r_m2_tail.zero    <= 1'b0;
            if (r_m1.in_soft) begin
                r_m2_den <= {49'd0, i_soft_radius_sq};
                for (int c = 0; c < 3; c++) begin
                    r_m2_num[c] <= {32'd0, r_m1.prod[c], 16'd0};
                end
            end else begin
                r_m2_den <= den_far;
                for (int c = 0; c < 3; c++) begin
                    r_m2_num[c] <= {r_m1.prod[c], 48'd0};
                end
            end
        end
    end

    // quotient range check and zero denominator
    logic                   r_m3_v;
    t_tail                  n_m3_tail;
    t_tail                  r_m3_tail;
    logic [WIDE_W-1:0]      r_m3_den;
    logic [2:0][WIDE_W-1:0] r_m3_num;

    always_comb begin
        n_m3_tail      = r_m2_tail;
        n_m3_tail.zero = (r_m2_den == '0);
        for (int c = 0; c < 3; c++) begin
            n_m3_tail.ovf[c] = ({32'd0, r_m2_num[c]} >= {r_m2_den, 32'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_v <= 1'b0;
        end else if (en) begin
            r_m3_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_tail <= n_m3_tail;
            r_m3_den  <= r_m2_den;
            r_m3_num  <= r_m2_num;
        end
    end

    // restoring division, one quotient bit per stage
    logic              r_dv_v    [DIV_STEPS];
    t_tail             r_dv_tail [DIV_STEPS];
    logic [WIDE_W-1:0] r_dv_den  [DIV_STEPS];
    logic [WIDE_W-1:0] r_dv_rem  [DIV_STEPS][3];
    logic [31:0]       r_dv_q    [DIV_STEPS][3];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int B = DIV_STEPS - 1 - s;
        logic              v_in;
        t_tail             tail_in;
        logic [WIDE_W-1:0] den_in;
        logic [CMP_W-1:0]  trial;

        if (s == 0) begin : g_first
            assign v_in    = r_m3_v;
            assign tail_in = r_m3_tail;
            assign den_in  = r_m3_den;
        end else begin : g_next
            assign v_in    = r_dv_v[s-1];
            assign tail_in = r_dv_tail[s-1];
            assign den_in  = r_dv_den[s-1];
        end

        assign trial = {32'd0, den_in} << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s] <= 1'b0;
            end else if (en) begin
                r_dv_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_tail[s] <= tail_in;
                r_dv_den[s]  <= den_in;
            end
        end

        for (genvar c = 0; c < 3; c++) begin : g_comp
            logic [WIDE_W-1:0] rem_in;
            logic [31:0]       q_in, q_set;

            if (s == 0) begin : g_first
                assign rem_in = r_m3_num[c];
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_dv_rem[s-1][c];
                assign q_in   = r_dv_q[s-1][c];
            end

            assign q_set = q_in | (32'd1 << B);

            always_ff @(posedge i_clk) begin
                if (en) begin
                    if ({32'd0, rem_in} >= trial) begin
                        r_dv_rem[s][c] <= rem_in - trial[WIDE_W-1:0];
                        r_dv_q[s][c]   <= q_set;
                    end else begin
                        r_dv_rem[s][c] <= rem_in;
                        r_dv_q[s][c]   <= q_in;
                    end
                end
            end
        end
    end

    // sign, clamp and output register
    t_tail       last_tail;
    logic [95:0] n_data;
    logic        n_sat;

    assign last_tail = r_dv_tail[DIV_STEPS-1];

    always_comb begin
        logic [32:0] limit;
        logic [31:0] q, mag;
        logic        clamp;
        n_sat = last_tail.sat;
        for (int c = 0; c < 3; c++) begin
            q     = r_dv_q[DIV_STEPS-1][c];
            limit = last_tail.neg[c] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
            clamp = last_tail.ovf[c] || ({1'b0, q} > limit);
            mag   = clamp ? limit[31:0] : q;
            if (last_tail.zero) begin
                n_data[c*32 +: 32] = '0;
            end else begin
                n_data[c*32 +: 32] = last_tail.neg[c] ? (~mag + 32'd1) : mag;
                n_sat = n_sat | clamp;
            end
        end
    end

    logic r_out_v;
    assign o_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data <= n_data;
            o_user <= {n_sat, last_tail.in_soft};
        end
    end

endmodule

`default_nettype wire
